// File: rtl/core/swcs_pkg.sv
package swcs_pkg;

	// fixed field widths
	localparam int TYPE_W   = 8;
	localparam int REQ_W    = 32;
	localparam int SEQ_W    = 16;
	localparam int LEN_W    = 24;
	localparam int CLEN_W   = 11;
	localparam int TRIES_W  = 8;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

	// register port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int REG_W  = 3;

	localparam int CHUNK_BYTES_DEF = 1024;
	localparam int MAX_TRIES_DEF   = 3;

	localparam logic [LEN_W-1:0] TIMEOUT_RESET = LEN_W'(1000);

	typedef enum logic [STATUS_W-1:0] {
		PH_IDLE       = 3'd0,
		PH_SEND_CHUNK = 3'd1,
		PH_AWAIT      = 3'd2,
		PH_SEND_DONE  = 3'd3,
		PH_DONE       = 3'd4,
		PH_FAILED     = 3'd5
	} phase_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_HEADER = 2'd2
	} cmd_t;

	typedef enum logic [REG_W-1:0] {
		REG_REQUEST_ID     = 3'd0,
		REG_CHUNK_MSG_TYPE = 3'd1,
		REG_DONE_MSG_TYPE  = 3'd2,
		REG_MESSAGE_LENGTH = 3'd3,
		REG_TIMEOUT_TICKS  = 3'd4,
		REG_ACK_CODE       = 3'd5,
		REG_NAK_CODE       = 3'd6,
		REG_ERR_CODE       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                 send_valid;
		logic [TYPE_W-1:0]    send_type;
		logic [SEQ_W-1:0]     send_sequence;
		logic [SEQ_W-1:0]     send_total;
		logic [LEN_W-1:0]     chunk_offset;
		logic [CLEN_W-1:0]    chunk_length;
		logic [STATUS_W-1:0]  sender_status;
		logic [TRIES_W-1:0]   tries_left;
	} result_t;

endpackage

// File: rtl/core/stop_wait_chunk_sender.sv
// Sending side of a chunked stop-and-wait transfer. Each command beat (start, one
// microsecond tick, or a received header) produces exactly one result beat, which
// carries the frame descriptor to send (if any) together with the sender status and
// the attempts left. One command is taken every cycle while cmd_stall is low. Its
// result is registered in a two-entry output stage (output register plus skid
// register), in the skid entry when the output is stalled, so the block can take a
// command while a result is still stalled; cmd_stall rises only when both entries
// are full. Start finds the chunk count with a single multiply by a constant
// reciprocal of CHUNK_BYTES, saturated at 65535; the chunk offset is kept as a
// running sum, so no multiplier sits in the tick path. Registers sit on a 32-bit
// APB port at byte address 4*i and may be changed only while no result is pending.
module stop_wait_chunk_sender #(
	parameter int CHUNK_BYTES = swcs_pkg::CHUNK_BYTES_DEF,
	parameter int MAX_TRIES   = swcs_pkg::MAX_TRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [swcs_pkg::ADDR_W-1:0]    paddr,
	input  logic [swcs_pkg::DATA_W-1:0]    pwdata,
	output logic [swcs_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,

	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [swcs_pkg::CMD_W-1:0]     command,
	input  logic [swcs_pkg::TYPE_W-1:0]    rx_type,
	input  logic [swcs_pkg::REQ_W-1:0]     rx_request,
	input  logic [swcs_pkg::SEQ_W-1:0]     rx_sequence,

	output logic                           res_valid,
	input  logic                           res_stall,
	output logic                           send_valid,
	output logic [swcs_pkg::TYPE_W-1:0]    send_type,
	output logic [swcs_pkg::SEQ_W-1:0]     send_sequence,
	output logic [swcs_pkg::SEQ_W-1:0]     send_total,
	output logic [swcs_pkg::LEN_W-1:0]     chunk_offset,
	output logic [swcs_pkg::CLEN_W-1:0]    chunk_length,
	output logic [swcs_pkg::STATUS_W-1:0]  sender_status,
	output logic [swcs_pkg::TRIES_W-1:0]   tries_left
);

	localparam int SEQ_W   = swcs_pkg::SEQ_W;
	localparam int LEN_W   = swcs_pkg::LEN_W;
	localparam int TYPE_W  = swcs_pkg::TYPE_W;
	localparam int TRIES_W = swcs_pkg::TRIES_W;

	// chunk count = floor((len + C - 1) / C) via exact reciprocal, numerator < 2^NUM_W
	localparam int NUM_W       = LEN_W + 1;
	localparam int RECIP_SHIFT = NUM_W + $clog2(CHUNK_BYTES);
	localparam int RECIP_W     = NUM_W + 1;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + longint'(CHUNK_BYTES) - 64'd1) / longint'(CHUNK_BYTES);
	localparam int PROD_W      = NUM_W + RECIP_W;

	// running byte offset; max is 65535 * CHUNK_BYTES
	localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
	localparam int OFF_W   = SEQ_W + CHUNK_W;
	localparam int CMP_W   = (OFF_W > LEN_W) ? OFF_W : LEN_W;

	localparam logic [TRIES_W-1:0] TRIES_INIT = TRIES_W'(MAX_TRIES);

	// configuration
	logic [swcs_pkg::REQ_W-1:0] request_id_q;
	logic [TYPE_W-1:0]          data_type_q;
	logic [TYPE_W-1:0]          fin_type_q;
	logic [LEN_W-1:0]           msg_len_q;
	logic [LEN_W-1:0]           timeout_q;
	logic [TYPE_W-1:0]          ack_code_q;
	logic [TYPE_W-1:0]          nak_code_q;
	logic [TYPE_W-1:0]          err_code_q;

	// sender state
	swcs_pkg::phase_t    phase_q, phase_d;
	logic [SEQ_W-1:0]    cur_q, cur_d;
	logic [SEQ_W-1:0]    count_q, count_d;
	logic [TRIES_W-1:0]  tries_q, tries_d;
	logic [LEN_W-1:0]    wait_q, wait_d;
	logic [OFF_W-1:0]    off_q, off_d;

	// output stage
	swcs_pkg::result_t   res_d, out_q, skid_q;
	logic                out_valid_q, skid_valid_q;

	logic                   wr_en;
	swcs_pkg::reg_idx_t     reg_idx;
	logic                   accept;
	logic                   out_free;
	swcs_pkg::cmd_t         cmd;

	logic [NUM_W-1:0]       num;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-1:0]      quot;
	logic [SEQ_W-1:0]       count_new;
	logic [SEQ_W-1:0]       cur_inc;
	logic [CMP_W-1:0]       off_ext;
	logic [CMP_W-1:0]       len_ext;
	logic [CMP_W-1:0]       rem;
	logic [CMP_W-1:0]       clen;
	logic                   hdr_match;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = swcs_pkg::reg_idx_t'(paddr[swcs_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_id_q <= '0;
			data_type_q  <= '0;
			fin_type_q   <= '0;
			msg_len_q    <= '0;
			timeout_q    <= swcs_pkg::TIMEOUT_RESET;
			ack_code_q   <= '0;
			nak_code_q   <= '0;
			err_code_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				swcs_pkg::REG_REQUEST_ID:     request_id_q <= pwdata;
				swcs_pkg::REG_CHUNK_MSG_TYPE: data_type_q  <= pwdata[TYPE_W-1:0];
				swcs_pkg::REG_DONE_MSG_TYPE:  fin_type_q   <= pwdata[TYPE_W-1:0];
				swcs_pkg::REG_MESSAGE_LENGTH: msg_len_q    <= pwdata[LEN_W-1:0];
				swcs_pkg::REG_TIMEOUT_TICKS:  timeout_q    <= pwdata[LEN_W-1:0];
				swcs_pkg::REG_ACK_CODE:       ack_code_q   <= pwdata[TYPE_W-1:0];
				swcs_pkg::REG_NAK_CODE:       nak_code_q   <= pwdata[TYPE_W-1:0];
				swcs_pkg::REG_ERR_CODE:       err_code_q   <= pwdata[TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			swcs_pkg::REG_REQUEST_ID:     prdata = request_id_q;
			swcs_pkg::REG_CHUNK_MSG_TYPE: prdata = swcs_pkg::DATA_W'(data_type_q);
			swcs_pkg::REG_DONE_MSG_TYPE:  prdata = swcs_pkg::DATA_W'(fin_type_q);
			swcs_pkg::REG_MESSAGE_LENGTH: prdata = swcs_pkg::DATA_W'(msg_len_q);
			swcs_pkg::REG_TIMEOUT_TICKS:  prdata = swcs_pkg::DATA_W'(timeout_q);
			swcs_pkg::REG_ACK_CODE:       prdata = swcs_pkg::DATA_W'(ack_code_q);
			swcs_pkg::REG_NAK_CODE:       prdata = swcs_pkg::DATA_W'(nak_code_q);
			swcs_pkg::REG_ERR_CODE:       prdata = swcs_pkg::DATA_W'(err_code_q);
			default:                      prdata = '0;
		endcase
	end

	assign accept = cmd_valid && !cmd_stall;
	assign cmd    = swcs_pkg::cmd_t'(command);

	// chunk count for start, saturated to 16 bits
	assign num       = NUM_W'(msg_len_q) + NUM_W'(CHUNK_BYTES - 1);
	assign prod      = PROD_W'(num) * PROD_W'(RECIP_W'(RECIP));
	assign quot      = prod >> RECIP_SHIFT;
	assign count_new = (quot > PROD_W'({SEQ_W{1'b1}})) ? {SEQ_W{1'b1}} : quot[SEQ_W-1:0];

	// descriptor of the pending chunk
	assign off_ext = CMP_W'(off_q);
	assign len_ext = CMP_W'(msg_len_q);
	assign rem     = (off_ext < len_ext) ? (len_ext - off_ext) : '0;
	assign clen    = (rem > CMP_W'(CHUNK_BYTES)) ? CMP_W'(CHUNK_BYTES) : rem;

	assign cur_inc   = cur_q + SEQ_W'(1);
	assign hdr_match = (phase_q == swcs_pkg::PH_AWAIT) && (rx_request == request_id_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		cur_d   = cur_q;
		count_d = count_q;
		tries_d = tries_q;
		wait_d  = wait_q;
		off_d   = off_q;
		case (cmd)
			swcs_pkg::CMD_START: begin
				count_d = count_new;
				cur_d   = '0;
				off_d   = '0;
				tries_d = TRIES_INIT;
				wait_d  = '0;
				phase_d = (msg_len_q == '0) ? swcs_pkg::PH_SEND_DONE
				                            : swcs_pkg::PH_SEND_CHUNK;
			end
			swcs_pkg::CMD_TICK: begin
				unique case (phase_q)
					swcs_pkg::PH_SEND_CHUNK: begin
						wait_d  = timeout_q;
						phase_d = swcs_pkg::PH_AWAIT;
					end
					swcs_pkg::PH_AWAIT: begin
						if (wait_q <= LEN_W'(1)) begin
							wait_d = '0;
							if (tries_q <= TRIES_W'(1)) begin
								tries_d = '0;
								phase_d = swcs_pkg::PH_FAILED;
							end else begin
								tries_d = tries_q - TRIES_W'(1);
								phase_d = swcs_pkg::PH_SEND_CHUNK;
							end
						end else begin
							wait_d = wait_q - LEN_W'(1);
						end
					end
					swcs_pkg::PH_SEND_DONE: phase_d = swcs_pkg::PH_DONE;
					default: ;
				endcase
			end
			swcs_pkg::CMD_HEADER: begin
				if (hdr_match) begin
					// a NAK or ERR wins over an ACK with the same code
					if (rx_type == nak_code_q || rx_type == err_code_q) begin
						phase_d = swcs_pkg::PH_FAILED;
					end else if (rx_type == ack_code_q && rx_sequence == cur_q) begin
						cur_d   = cur_inc;
						off_d   = off_q + OFF_W'(CHUNK_BYTES);
						tries_d = TRIES_INIT;
						wait_d  = '0;
						phase_d = (cur_inc >= count_q) ? swcs_pkg::PH_SEND_DONE
						                               : swcs_pkg::PH_SEND_CHUNK;
					end
				end
			end
			default: ;
		endcase
	end

	// result of this command
	always_comb begin
		res_d               = '0;
		res_d.sender_status = phase_d;
		res_d.tries_left    = tries_d;
		if (cmd == swcs_pkg::CMD_TICK) begin
			if (phase_q == swcs_pkg::PH_SEND_CHUNK) begin
				res_d.send_valid    = 1'b1;
				res_d.send_type     = data_type_q;
				res_d.send_sequence = cur_q;
				res_d.send_total    = count_q;
				res_d.chunk_offset  = off_ext[LEN_W-1:0];
				res_d.chunk_length  = clen[swcs_pkg::CLEN_W-1:0];
			end else if (phase_q == swcs_pkg::PH_SEND_DONE) begin
				res_d.send_valid = 1'b1;
				res_d.send_type  = fin_type_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swcs_pkg::PH_IDLE;
			cur_q   <= '0;
			count_q <= '0;
			tries_q <= '0;
			wait_q  <= '0;
			off_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cur_q   <= cur_d;
			count_q <= count_d;
			tries_q <= tries_d;
			wait_q  <= wait_d;
			off_q   <= off_d;
		end
	end

	// output register with skid; input stalls only when the skid entry is full
	assign out_free  = !out_valid_q || !res_stall;
	assign cmd_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_free) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_free) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign res_valid     = out_valid_q;
	assign send_valid    = out_q.send_valid;
	assign send_type     = out_q.send_type;
	assign send_sequence = out_q.send_sequence;
	assign send_total    = out_q.send_total;
	assign chunk_offset  = out_q.chunk_offset;
	assign chunk_length  = out_q.chunk_length;
	assign sender_status = out_q.sender_status;
	assign tries_left    = out_q.tries_left;

endmodule
